// File: design/hsvp_pkg.sv
// ----------------------------------------------------------------------------
// hsvp_pkg
// Shared types, constants and helpers for the hsv to packed rgba pipeline.
// ----------------------------------------------------------------------------
package hsvp_pkg;

  // fixed point format
  localparam int unsigned FracBits = 16;
  localparam int unsigned QW       = FracBits + 1;       // q1.16 width
  localparam logic [QW-1:0] OneQ16 = QW'(1) << FracBits;
  localparam logic [8:0] ChanMax   = 9'd255;

  // hue sectors, each one sixth of a turn
  localparam logic [2:0] SEC_RED_YEL = 3'd0;
  localparam logic [2:0] SEC_YEL_GRN = 3'd1;
  localparam logic [2:0] SEC_GRN_CYN = 3'd2;
  localparam logic [2:0] SEC_CYN_BLU = 3'd3;
  localparam logic [2:0] SEC_BLU_MAG = 3'd4;

  // after clamp and sector split
  typedef struct packed {
    logic [QW-1:0]       sat;
    logic [QW-1:0]       bri;
    logic [QW-1:0]       alp;
    logic [2:0]          sector;
    logic [FracBits-1:0] frac;
  } split_t;

  // after the saturation products
  typedef struct packed {
    logic [QW-1:0] bri;
    logic [QW-1:0] alp;
    logic [QW-1:0] oms;    // 1 - s
    logic [QW-1:0] omsf;   // 1 - s*f
    logic [QW-1:0] omst;   // 1 - s*(1-f)
    logic [2:0]    sector;
  } coef_t;

  // after the brightness products
  typedef struct packed {
    logic [QW-1:0] bri;
    logic [QW-1:0] alp;
    logic [QW-1:0] p;
    logic [QW-1:0] q;
    logic [QW-1:0] t;
    logic [2:0]    sector;
  } chan_t;

  // saturate a q1.16 value at 1.0
  function automatic logic [QW-1:0] clamp_one(input logic [QW-1:0] v);
    clamp_one = (v > OneQ16) ? OneQ16 : v;
  endfunction

  // floor(x*255) with saturation at 255
  function automatic logic [7:0] to_byte(input logic [QW-1:0] x);
    logic [QW+7:0] m;
    logic [8:0]    v;
    m = ({8'd0, x} << 8) - {8'd0, x};
    v = m[QW+7:FracBits];
    to_byte = (v > ChanMax) ? 8'hff : v[7:0];
  endfunction

endpackage

// File: design/hsvp_split.sv
// ----------------------------------------------------------------------------
// hsvp_split
// First stage: clamps s, b and a to 1.0 and splits hue*6 into sector and
// fraction.
// ----------------------------------------------------------------------------
module hsvp_split import hsvp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [FracBits-1:0] hue_i,
  input  logic [QW-1:0]       saturation_i,
  input  logic [QW-1:0]       brightness_i,
  input  logic [QW-1:0]       alpha_i,
  output logic                valid_o,
  input  logic                ready_i,
  output split_t              data_o
);

  logic              valid_q;
  split_t            data_d, data_q;
  logic              adv;
  logic [FracBits+2:0] hh;

  // stage moves when empty or when downstream takes its word
  assign adv     = !valid_q || ready_i;
  assign ready_o = adv;

  // hue*6 as shift and add
  always_comb begin
    hh            = ({3'd0, hue_i} << 2) + ({3'd0, hue_i} << 1);
    data_d.sat    = clamp_one(saturation_i);
    data_d.bri    = clamp_one(brightness_i);
    data_d.alp    = clamp_one(alpha_i);
    data_d.sector = hh[FracBits+2:FracBits];
    data_d.frac   = hh[FracBits-1:0];
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: design/hsvp_coef.sv
// ----------------------------------------------------------------------------
// hsvp_coef
// Second stage: forms 1-s, 1-s*f and 1-s*(1-f) with truncated products.
// ----------------------------------------------------------------------------
module hsvp_coef import hsvp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  split_t data_i,
  output logic   valid_o,
  input  logic   ready_i,
  output coef_t  data_o
);

  logic            valid_q;
  coef_t           data_d, data_q;
  logic            adv;
  logic [QW-1:0]   omf;
  logic [2*QW-1:0] sf_prod;
  logic [2*QW-1:0] sof_prod;

  assign adv     = !valid_q || ready_i;
  assign ready_o = adv;

  // saturation products
  always_comb begin
    omf           = OneQ16 - {1'b0, data_i.frac};
    sf_prod       = {{QW{1'b0}}, data_i.sat} * {{QW{1'b0}}, {1'b0, data_i.frac}};
    sof_prod      = {{QW{1'b0}}, data_i.sat} * {{QW{1'b0}}, omf};
    data_d.bri    = data_i.bri;
    data_d.alp    = data_i.alp;
    data_d.oms    = OneQ16 - data_i.sat;
    data_d.omsf   = OneQ16 - sf_prod[FracBits+QW-1:FracBits];
    data_d.omst   = OneQ16 - sof_prod[FracBits+QW-1:FracBits];
    data_d.sector = data_i.sector;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: design/hsvp_scale.sv
// ----------------------------------------------------------------------------
// hsvp_scale
// Third stage: scales the coefficients by brightness to give p, q and t.
// ----------------------------------------------------------------------------
module hsvp_scale import hsvp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  coef_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output chan_t data_o
);

  logic            valid_q;
  chan_t           data_d, data_q;
  logic            adv;
  logic [2*QW-1:0] p_prod;
  logic [2*QW-1:0] q_prod;
  logic [2*QW-1:0] t_prod;

  assign adv     = !valid_q || ready_i;
  assign ready_o = adv;

  // brightness products, all at most 1.0
  always_comb begin
    p_prod        = {{QW{1'b0}}, data_i.bri} * {{QW{1'b0}}, data_i.oms};
    q_prod        = {{QW{1'b0}}, data_i.bri} * {{QW{1'b0}}, data_i.omsf};
    t_prod        = {{QW{1'b0}}, data_i.bri} * {{QW{1'b0}}, data_i.omst};
    data_d.bri    = data_i.bri;
    data_d.alp    = data_i.alp;
    data_d.p      = p_prod[FracBits+QW-1:FracBits];
    data_d.q      = q_prod[FracBits+QW-1:FracBits];
    data_d.t      = t_prod[FracBits+QW-1:FracBits];
    data_d.sector = data_i.sector;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: design/hsvp_pack.sv
// ----------------------------------------------------------------------------
// hsvp_pack
// Last stage: picks red, green and blue by sector, scales to bytes and
// holds the packed word in the output register.
// ----------------------------------------------------------------------------
module hsvp_pack import hsvp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  chan_t       data_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [31:0] word_o
);

  logic          valid_q;
  logic [31:0]   word_d, word_q;
  logic          adv;
  logic [QW-1:0] red, grn, blu;

  assign adv     = !valid_q || ready_i;
  assign ready_o = adv;

  // channel selection by sector
  always_comb begin
    case (data_i.sector)
      SEC_RED_YEL: begin red = data_i.bri; grn = data_i.t;   blu = data_i.p;   end
      SEC_YEL_GRN: begin red = data_i.q;   grn = data_i.bri; blu = data_i.p;   end
      SEC_GRN_CYN: begin red = data_i.p;   grn = data_i.bri; blu = data_i.t;   end
      SEC_CYN_BLU: begin red = data_i.p;   grn = data_i.q;   blu = data_i.bri; end
      SEC_BLU_MAG: begin red = data_i.t;   grn = data_i.p;   blu = data_i.bri; end
      default:     begin red = data_i.bri; grn = data_i.p;   blu = data_i.q;   end
    endcase
    word_d = {to_byte(data_i.alp), to_byte(blu), to_byte(grn), to_byte(red)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// File: design/hsv_to_rgba_pack_top.sv
// ----------------------------------------------------------------------------
// hsv_to_rgba_pack_top
// HSV to packed 8-bit RGBA color converter, four register stages.
// ----------------------------------------------------------------------------
// usage
//   input channel: hue (q0.16 turn), saturation, brightness, alpha (q1.16,
//   values above 1.0 are taken as 1.0) with in_valid_i / in_stall_o.
//   output channel: packed_color_o = {alpha, blue, green, red} bytes with
//   out_valid_o / out_stall_i.
//   a word accepted at the input passes the split, coef, scale and pack
//   registers in order before it shows at the output.
//   throughput: one word per cycle while out_stall_i is low; the four
//   stages are clamp and sector split, saturation products (two 17x17
//   multipliers), brightness products (three 17x17 multipliers),
//   channel select and byte scaling. each stage has its own valid bit and
//   loads whenever it is empty or its successor moves, so bubbles are squeezed out under back pressure.
//   when the receiver stalls, the output word holds and the pipe keeps
//   filling; in_stall_o rises only when all four stages are full.
//   reset clears every valid bit; no word is pending after reset.
// ----------------------------------------------------------------------------
module hsv_to_rgba_pack_top import hsvp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] hue_i,
  input  logic [16:0] saturation_i,
  input  logic [16:0] brightness_i,
  input  logic [16:0] alpha_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] packed_color_o
);

  logic   in_ready;
  logic   split_valid, split_ready;
  logic   coef_valid, coef_ready;
  logic   scale_valid, scale_ready;
  split_t split_data;
  coef_t  coef_data;
  chan_t  scale_data;

  // clamp and sector split
  hsvp_split u_split (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_valid_i),
    .ready_o      (in_ready),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .alpha_i      (alpha_i),
    .valid_o      (split_valid),
    .ready_i      (split_ready),
    .data_o       (split_data)
  );

  // saturation products
  hsvp_coef u_coef (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (split_valid),
    .ready_o (split_ready),
    .data_i  (split_data),
    .valid_o (coef_valid),
    .ready_i (coef_ready),
    .data_o  (coef_data)
  );

  // brightness products
  hsvp_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (coef_valid),
    .ready_o (coef_ready),
    .data_i  (coef_data),
    .valid_o (scale_valid),
    .ready_i (scale_ready),
    .data_o  (scale_data)
  );

  // channel select and packing, output register
  hsvp_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (scale_valid),
    .ready_o (scale_ready),
    .data_i  (scale_data),
    .valid_o (out_valid_o),
    .ready_i (!out_stall_i),
    .word_o  (packed_color_o)
  );

  assign in_stall_o = !in_ready;

endmodule

// File: design/hsvp_checker.sv
// ----------------------------------------------------------------------------
// hsvp_checker
// Port-level checks for the hsv to packed rgba converter.
// ----------------------------------------------------------------------------
module hsvp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] packed_color_o
);

  // a stalled word stays offered
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // a stalled word keeps its value
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(packed_color_o))
    else $error("output word changed while stalled");

  // input back pressure only when the whole pipe is full and blocked
  a_in_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with room in the pipe");

  // a word rising at an empty output matches an accepted input word
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 4))
    else $error("output word without matching input word");

endmodule

bind hsv_to_rgba_pack_top hsvp_checker u_hsvp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .packed_color_o (packed_color_o)
);
